// File: rtl/tst_pkg.sv
package tst_pkg;

   localparam int MaxResults = 16;
   localparam int FireCntW   = $clog2(MaxResults + 1);
   localparam int SlotW      = 4;

   localparam logic [1:0] OP_ARM_ONESHOT  = 2'd0;
   localparam logic [1:0] OP_ARM_PERIODIC = 2'd1;
   localparam logic [1:0] OP_CANCEL       = 2'd2;
   localparam logic [1:0] OP_TICK         = 2'd3;

   localparam logic [1:0] KIND_ARM    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;
   localparam logic [1:0] KIND_IDLE   = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] now_time;
      logic [31:0] interval;
      logic [31:0] tag;
      logic [7:0]  cancel_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             ok;
      logic [SlotW-1:0] slot;
      logic [31:0]      fired_tag;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] due;
      logic [31:0] period;
      logic [31:0] tag;
   } slot_entry_type;

endpackage

// File: rtl/tst_ram.sv
module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/timer_slot_table_top.sv
// Timer slot table.
// Request channel: a transaction (req) is taken at a clock edge with start high
// and busy low. op selects arm one-shot, arm periodic, cancel or tick.
// Response channel: each result sits on rsp for one cycle with rsp_valid high;
// the receiver must take it then, there is no backpressure.
// Arm and cancel: busy for 1 cycle; the single result is registered out of
// the ARM or CANCEL state, and a new request can be taken in the cycle the
// result shows. Tick: the slots are read one per cycle through the single read
// port of the slot RAM; a fired periodic entry is written back with its next
// due time in the cycle after its read. Fired results stream out during the
// scan, or one idle result if none fires; the final one (last = 1) shows in
// the cycle busy drops. At most 16 slots fire per tick. Reset clears all active
// bits and control state, not the slot RAM: its entries count only while armed.
module timer_slot_table_top
   import tst_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CntW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ARM    = 4'b0010,
      ST_CANCEL = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [NUM_SLOTS-1:0]    active_ff, active_in;
   logic [CntW-1:0]         idx_ff, idx_in;
   logic                    p_valid_ff, p_valid_in;
   logic [IdxW-1:0]         p_idx_ff, p_idx_in;
   logic [FireCntW-1:0]     fire_cnt_ff, fire_cnt_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic [IdxW-1:0]         hold_slot_ff, hold_slot_in;
   logic [31:0]             hold_tag_ff, hold_tag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    free_found;
   logic [IdxW-1:0]         free_idx;
   logic                    issue;
   logic                    due_hit;
   logic [31:0]             diff;
   logic                    in_range;

   logic                    ram_we;
   logic [IdxW-1:0]         ram_waddr;
   slot_entry_type          ram_wdata;
   slot_entry_type          ram_rdata;
   logic [$bits(slot_entry_type)-1:0] ram_rbits;

   tst_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (idx_ff[IdxW-1:0]),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = slot_entry_type'(ram_rbits);

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
      end
   end

   assign in_range = (req_ff.cancel_handle < 8'(NUM_SLOTS));
   assign issue    = (state_ff == ST_SCAN) && (idx_ff != CntW'(NUM_SLOTS))
                     && (fire_cnt_ff != FireCntW'(MaxResults));
   assign diff     = req_ff.now_time - ram_rdata.due;
   assign due_hit  = p_valid_ff && active_ff[p_idx_ff] && !diff[31]
                     && (fire_cnt_ff != FireCntW'(MaxResults));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      active_in     = active_ff;
      idx_in        = idx_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = idx_ff[IdxW-1:0];
      fire_cnt_in   = fire_cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      hold_tag_in   = hold_tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '{kind: KIND_ARM, ok: 1'b0, slot: '0, fired_tag: '0, last: 1'b1};
      ram_we        = 1'b0;
      ram_waddr     = free_idx;
      ram_wdata     = '{due: req_ff.now_time + req_ff.interval,
                        period: (req_ff.op == OP_ARM_PERIODIC) ? req_ff.interval : '0,
                        tag: req_ff.tag};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req;
               idx_in        = '0;
               fire_cnt_in   = '0;
               hold_valid_in = 1'b0;
               if (req.op inside {OP_ARM_ONESHOT, OP_ARM_PERIODIC}) begin
                  state_in = ST_ARM;
               end else if (req.op == OP_CANCEL) begin
                  state_in = ST_CANCEL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ARM: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = KIND_ARM;
            rsp_in.ok    = free_found;
            if (free_found) begin
               rsp_in.slot         = SlotW'(free_idx);
               active_in[free_idx] = 1'b1;
               ram_we              = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_CANCEL: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = KIND_CANCEL;
            rsp_in.ok    = in_range;
            if (in_range) begin
               rsp_in.slot = SlotW'(req_ff.cancel_handle);
               active_in[req_ff.cancel_handle[IdxW-1:0]] = 1'b0;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (issue) begin
               p_valid_in = 1'b1;
               idx_in     = idx_ff + CntW'(1);
            end
            if (due_hit) begin
               fire_cnt_in   = fire_cnt_ff + FireCntW'(1);
               hold_valid_in = 1'b1;
               hold_slot_in  = p_idx_ff;
               hold_tag_in   = ram_rdata.tag;
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{kind: KIND_FIRED, ok: 1'b1, slot: SlotW'(hold_slot_ff),
                                   fired_tag: hold_tag_ff, last: 1'b0};
               end
               ram_waddr = p_idx_ff;
               if (ram_rdata.period != '0) begin
                  ram_we    = 1'b1;
                  ram_wdata = '{due: ram_rdata.due + ram_rdata.period,
                                period: ram_rdata.period, tag: ram_rdata.tag};
               end else begin
                  active_in[p_idx_ff] = 1'b0;
               end
            end
            if (!issue && !p_valid_ff) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_in = '{kind: KIND_FIRED, ok: 1'b1, slot: SlotW'(hold_slot_ff),
                             fired_tag: hold_tag_ff, last: 1'b1};
               end else begin
                  rsp_in = '{kind: KIND_IDLE, ok: 1'b1, slot: '0, fired_tag: '0,
                             last: 1'b1};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         idx_ff        <= '0;
         p_valid_ff    <= 1'b0;
         fire_cnt_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         idx_ff        <= idx_in;
         p_valid_ff    <= p_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      p_idx_ff     <= p_idx_in;
      hold_slot_ff <= hold_slot_in;
      hold_tag_ff  <= hold_tag_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/tst_checker.sv
module tst_checker
   import tst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req,
   input logic    rsp_valid,
   input rsp_type rsp
);

   property p_accept_busy;
      @(posedge clock) disable iff (reset) (start && !busy) |=> busy;
   endproperty
   a_accept_busy: assert property (p_accept_busy)
      else $error("accepted transaction did not raise busy");

   property p_last_gap;
      @(posedge clock) disable iff (reset) (rsp_valid && rsp.last) |=> !rsp_valid;
   endproperty
   a_last_gap: assert property (p_last_gap)
      else $error("result directly after final result");

   property p_notlast_fired;
      @(posedge clock) disable iff (reset) (rsp_valid && !rsp.last) |-> (rsp.kind == KIND_FIRED);
   endproperty
   a_notlast_fired: assert property (p_notlast_fired)
      else $error("non-final result is not a fired result");

   property p_notlast_busy;
      @(posedge clock) disable iff (reset) (rsp_valid && !rsp.last) |-> busy;
   endproperty
   a_notlast_busy: assert property (p_notlast_busy)
      else $error("non-final result while idle");

   property p_idle_kind;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp.kind == KIND_IDLE) |-> (rsp.last && rsp.ok);
   endproperty
   a_idle_kind: assert property (p_idle_kind)
      else $error("nothing-due result malformed");

endmodule

bind timer_slot_table_top tst_checker u_tst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
